// ===== rtl/core/chip8_instruction_core_defines.svh =====
// Assertion macros used by the core's controller.
`ifndef CHIP8_INSTRUCTION_CORE_DEFINES_SVH
`define CHIP8_INSTRUCTION_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CIC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("chip8 core: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define CIC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("chip8 core: next-cycle check failed");

`endif

// ===== rtl/core/cic_pkg.sv =====
package cic_pkg;

  localparam int MEM_DEPTH  = 4096;
  localparam int SCREEN_ROWS = 32;
  localparam int SCREEN_COLS = 64;
  localparam int NUM_REGS   = 16;
  localparam int FONT_BYTES = 80;

  localparam logic [11:0] START_PC  = 12'h200;
  localparam logic [11:0] FONT_BASE = 12'h050;
  localparam logic [11:0] SYS_CLS   = 12'h0E0;
  localparam logic [11:0] SYS_RET   = 12'h0EE;
  localparam logic [3:0]  REG_VF    = 4'hF;

  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_EXEC = 2'd1;
  localparam logic [1:0] MODE_ROW  = 2'd2;

  // Opcode groups (top nibble).
  localparam logic [3:0] OPG_SYS   = 4'h0;
  localparam logic [3:0] OPG_JP    = 4'h1;
  localparam logic [3:0] OPG_CALL  = 4'h2;
  localparam logic [3:0] OPG_SE    = 4'h3;
  localparam logic [3:0] OPG_SNE   = 4'h4;
  localparam logic [3:0] OPG_SER   = 4'h5;
  localparam logic [3:0] OPG_LDI   = 4'h6;
  localparam logic [3:0] OPG_ADDI  = 4'h7;
  localparam logic [3:0] OPG_ALU   = 4'h8;
  localparam logic [3:0] OPG_SNER  = 4'h9;
  localparam logic [3:0] OPG_LDIDX = 4'hA;
  localparam logic [3:0] OPG_JPV0  = 4'hB;
  localparam logic [3:0] OPG_RND   = 4'hC;
  localparam logic [3:0] OPG_DRW   = 4'hD;
  localparam logic [3:0] OPG_KEY   = 4'hE;
  localparam logic [3:0] OPG_MISC  = 4'hF;

  localparam logic [3:0] ALU_MOV = 4'h0;
  localparam logic [3:0] ALU_OR  = 4'h1;
  localparam logic [3:0] ALU_AND = 4'h2;
  localparam logic [3:0] ALU_XOR = 4'h3;
  localparam logic [3:0] ALU_ADD = 4'h4;
  localparam logic [3:0] ALU_SUB = 4'h5;
  localparam logic [3:0] ALU_SHR = 4'h6;
  localparam logic [3:0] ALU_SBN = 4'h7;
  localparam logic [3:0] ALU_SHL = 4'hE;

  localparam logic [7:0] KEY_DOWN = 8'h9E;
  localparam logic [7:0] KEY_UP   = 8'hA1;

  localparam logic [7:0] FN_GET_DT = 8'h07;
  localparam logic [7:0] FN_WAITK  = 8'h0A;
  localparam logic [7:0] FN_SET_DT = 8'h15;
  localparam logic [7:0] FN_SET_ST = 8'h18;
  localparam logic [7:0] FN_ADD_I  = 8'h1E;
  localparam logic [7:0] FN_FONT   = 8'h29;
  localparam logic [7:0] FN_BCD    = 8'h33;
  localparam logic [7:0] FN_STORE  = 8'h55;
  localparam logic [7:0] FN_LOAD   = 8'h65;

  localparam logic [7:0] FONT [FONT_BYTES] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  typedef enum logic [4:0] {
    CMD_IDLE, CMD_CLEAR, CMD_MEMWR, CMD_ROWRD, CMD_ROWCAP,
    CMD_F1, CMD_F2, CMD_F3, CMD_F4, CMD_F5, CMD_F6,
    CMD_EXEC, CMD_WRX, CMD_RET, CMD_CLS,
    CMD_DRAW_RD, CMD_DRAW_WR, CMD_DRAW_VF, CMD_BCD,
    CMD_STORE_RD, CMD_STORE_WR, CMD_LOAD_RD, CMD_LOAD_WR,
    CMD_TICK, CMD_DONE
  } cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic accept;
  } ctl_t;

  typedef struct packed {
    logic [15:0] op;
    logic        last;
  } sts_t;

  // Initial memory contents: the hex font, zero elsewhere.
  function automatic logic [7:0] font_at(input logic [11:0] addr);
    logic [11:0] off;
    off = addr - FONT_BASE;
    if (addr >= FONT_BASE && off < 12'(FONT_BYTES)) return FONT[off[6:0]];
    return 8'h00;
  endfunction

  function automatic logic alu_known(input logic [3:0] n);
    return (n <= ALU_SBN) || (n == ALU_SHL);
  endfunction

  function automatic logic alu_sets_flag(input logic [3:0] n);
    return (n >= ALU_ADD && n <= ALU_SBN) || (n == ALU_SHL);
  endfunction

  function automatic logic alu_flag(input logic [3:0] n, input logic [7:0] a,
                                    input logic [7:0] b);
    logic [8:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    case (n)
      ALU_ADD: return sum[8];
      ALU_SUB: return a >= b;
      ALU_SHR: return a[0];
      ALU_SBN: return b >= a;
      ALU_SHL: return a[7];
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [7:0] alu_result(input logic [3:0] n, input logic [7:0] a,
                                            input logic [7:0] b);
    case (n)
      ALU_MOV: return b;
      ALU_OR:  return a | b;
      ALU_AND: return a & b;
      ALU_XOR: return a ^ b;
      ALU_ADD: return a + b;
      ALU_SUB: return a - b;
      ALU_SHR: return {1'b0, a[7:1]};
      ALU_SBN: return b - a;
      ALU_SHL: return {a[6:0], 1'b0};
      default: return a;
    endcase
  endfunction

  // Decimal digit of an 8-bit value: hundreds, tens or ones, by reciprocal multiply.
  function automatic logic [7:0] bcd_digit(input logic [7:0] v, input logic [1:0] sel);
    logic [13:0] ph;
    logic [1:0]  h;
    logic [7:0]  r;
    logic [14:0] pt;
    logic [3:0]  t;
    logic [7:0]  o;
    ph = 14'(v) * 14'd41;
    h  = ph[13:12];
    r  = v - 8'(h) * 8'd100;
    pt = 15'(r) * 15'd205;
    t  = pt[14:11];
    o  = r - 8'(t) * 8'd10;
    case (sel)
      2'd0:    return 8'(h);
      2'd1:    return 8'(t);
      default: return o;
    endcase
  endfunction

endpackage

// ===== rtl/core/cic_ram.sv =====
module cic_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         q
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    q <= mem[raddr];
  end

endmodule

// ===== rtl/core/cic_ctrl.sv =====
`include "chip8_instruction_core_defines.svh"

module cic_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [1:0]    mode,
  input  cic_pkg::sts_t sts,
  output cic_pkg::ctl_t ctl,
  output logic          busy,
  output logic          done
);
  import cic_pkg::*;

  typedef enum logic [24:0] {
    ST_CLEAR    = 25'h0000001,
    ST_IDLE     = 25'h0000002,
    ST_MEMWR    = 25'h0000004,
    ST_ROWRD    = 25'h0000008,
    ST_ROWCAP   = 25'h0000010,
    ST_F1       = 25'h0000020,
    ST_F2       = 25'h0000040,
    ST_F3       = 25'h0000080,
    ST_F4       = 25'h0000100,
    ST_F5       = 25'h0000200,
    ST_F6       = 25'h0000400,
    ST_EXEC     = 25'h0000800,
    ST_WRX      = 25'h0001000,
    ST_RET      = 25'h0002000,
    ST_CLS      = 25'h0004000,
    ST_DRAW_RD  = 25'h0008000,
    ST_DRAW_WR  = 25'h0010000,
    ST_DRAW_VF  = 25'h0020000,
    ST_BCD      = 25'h0040000,
    ST_STORE_RD = 25'h0080000,
    ST_STORE_WR = 25'h0100000,
    ST_LOAD_RD  = 25'h0200000,
    ST_LOAD_WR  = 25'h0400000,
    ST_TICK     = 25'h0800000,
    ST_DONE     = 25'h1000000
  } state_t;

  state_t state, state_next;
  logic [3:0] opg, n;
  logic [7:0] nn;

  assign opg = sts.op[15:12];
  assign n   = sts.op[3:0];
  assign nn  = sts.op[7:0];

  assign busy       = (state != ST_IDLE);
  assign done       = (state == ST_DONE);

  always_comb begin
    state_next = state;
    ctl.accept = start && (state == ST_IDLE);
    ctl.cmd    = CMD_IDLE;
    case (state)
      ST_CLEAR: begin
        ctl.cmd = CMD_CLEAR;
        if (sts.last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        ctl.cmd = CMD_IDLE;
        if (start) begin
          case (mode)
            MODE_LOAD: state_next = ST_MEMWR;
            MODE_EXEC: state_next = ST_F1;
            MODE_ROW:  state_next = ST_ROWRD;
            default:   state_next = ST_DONE;
          endcase
        end
      end
      ST_MEMWR:  begin ctl.cmd = CMD_MEMWR;  state_next = ST_DONE;   end
      ST_ROWRD:  begin ctl.cmd = CMD_ROWRD;  state_next = ST_ROWCAP; end
      ST_ROWCAP: begin ctl.cmd = CMD_ROWCAP; state_next = ST_DONE;   end
      ST_F1:     begin ctl.cmd = CMD_F1;     state_next = ST_F2;     end
      ST_F2:     begin ctl.cmd = CMD_F2;     state_next = ST_F3;     end
      ST_F3:     begin ctl.cmd = CMD_F3;     state_next = ST_F4;     end
      ST_F4:     begin ctl.cmd = CMD_F4;     state_next = ST_F5;     end
      ST_F5:     begin ctl.cmd = CMD_F5;     state_next = ST_F6;     end
      ST_F6:     begin ctl.cmd = CMD_F6;     state_next = ST_EXEC;   end
      ST_EXEC: begin
        ctl.cmd    = CMD_EXEC;
        state_next = ST_TICK;
        case (opg)
          OPG_SYS: begin
            if (sts.op[11:0] == SYS_CLS) state_next = ST_CLS;
            else if (sts.op[11:0] == SYS_RET) state_next = ST_RET;
          end
          OPG_ALU: if (alu_sets_flag(n)) state_next = ST_WRX;
          OPG_DRW: state_next = (n == 4'd0) ? ST_DRAW_VF : ST_DRAW_RD;
          OPG_MISC: begin
            if (nn == FN_BCD) state_next = ST_BCD;
            else if (nn == FN_STORE) state_next = ST_STORE_RD;
            else if (nn == FN_LOAD) state_next = ST_LOAD_RD;
          end
          default: state_next = ST_TICK;
        endcase
      end
      ST_WRX: begin ctl.cmd = CMD_WRX; state_next = ST_TICK; end
      ST_RET: begin ctl.cmd = CMD_RET; state_next = ST_TICK; end
      ST_CLS: begin
        ctl.cmd = CMD_CLS;
        if (sts.last) state_next = ST_TICK;
      end
      ST_DRAW_RD: begin ctl.cmd = CMD_DRAW_RD; state_next = ST_DRAW_WR; end
      ST_DRAW_WR: begin
        ctl.cmd    = CMD_DRAW_WR;
        state_next = sts.last ? ST_DRAW_VF : ST_DRAW_RD;
      end
      ST_DRAW_VF: begin ctl.cmd = CMD_DRAW_VF; state_next = ST_TICK; end
      ST_BCD: begin
        ctl.cmd = CMD_BCD;
        if (sts.last) state_next = ST_TICK;
      end
      ST_STORE_RD: begin ctl.cmd = CMD_STORE_RD; state_next = ST_STORE_WR; end
      ST_STORE_WR: begin
        ctl.cmd    = CMD_STORE_WR;
        state_next = sts.last ? ST_TICK : ST_STORE_RD;
      end
      ST_LOAD_RD: begin ctl.cmd = CMD_LOAD_RD; state_next = ST_LOAD_WR; end
      ST_LOAD_WR: begin
        ctl.cmd    = CMD_LOAD_WR;
        state_next = sts.last ? ST_TICK : ST_LOAD_RD;
      end
      ST_TICK: begin ctl.cmd = CMD_TICK; state_next = ST_DONE; end
      ST_DONE: begin ctl.cmd = CMD_DONE; state_next = ST_IDLE; end
      default: begin ctl.cmd = CMD_IDLE; state_next = ST_IDLE; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  `CIC_ASSERT_NXT(a_accept_busy, clk, rst, start && !busy, busy)
  `CIC_ASSERT_NXT(a_done_pulse, clk, rst, done, !done)
  `CIC_ASSERT_NXT(a_done_idle, clk, rst, done, !busy)

endmodule

// ===== rtl/core/cic_datapath.sv =====
module cic_datapath #(
  parameter int STACK_DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  cic_pkg::ctl_t ctl,
  output cic_pkg::sts_t sts,
  input  logic [1:0]    mode,
  input  logic [11:0]   address,
  input  logic [7:0]    data_byte,
  input  logic [15:0]   keys,
  input  logic [7:0]    random_byte,
  input  logic [4:0]    row_index,
  output logic [11:0]   program_counter,
  output logic [15:0]   instruction,
  output logic          display_changed,
  output logic          sound_on,
  output logic          unknown_opcode,
  output logic          waiting_for_key,
  output logic [63:0]   row_pixels
);
  import cic_pkg::*;

  localparam int SAW = $clog2(STACK_DEPTH);
  localparam logic [SAW-1:0] SP_LAST = SAW'(STACK_DEPTH - 1);

  // Latched transaction inputs.
  logic [1:0]  in_mode;
  logic [11:0] in_addr;
  logic [7:0]  in_data;
  logic [15:0] in_keys;
  logic [7:0]  in_rand;
  logic [4:0]  in_row;

  logic [15:0] op;
  logic [7:0]  vx, vy, v0;
  logic [11:0] idx, pc, cnt;
  logic [SAW-1:0] sp;
  logic [7:0]  dt, st;
  logic        flag, coll, changed, unk, waiting;
  logic [63:0] row_r;

  logic        mem_we;
  logic [11:0] mem_waddr, mem_raddr;
  logic [7:0]  mem_wdata, mem_q;
  logic        disp_we;
  logic [4:0]  disp_waddr, disp_raddr;
  logic [63:0] disp_wdata, disp_q;
  logic        reg_we;
  logic [3:0]  reg_waddr, reg_raddr;
  logic [7:0]  reg_wdata, reg_q;
  logic        stk_we;
  logic [SAW-1:0] stk_raddr;
  logic [11:0] stk_q;

  logic [3:0]  x, y, n, opg, kidx;
  logic [7:0]  nn;
  logic [11:0] nnn, i_off;
  logic [4:0]  drow;
  logic [63:0] spr, mask;
  logic [127:0] rot;
  logic [12:0] i_sum;
  logic [SAW-1:0] sp_dec, sp_inc;
  logic        key_hit, key_any, loop_cmd, inc_cmd;
  logic [7:0]  ax, by;

  assign opg = op[15:12];
  assign x   = op[11:8];
  assign y   = op[7:4];
  assign n   = op[3:0];
  assign nn  = op[7:0];
  assign nnn = op[11:0];

  assign i_off  = idx + cnt;
  assign drow   = vy[4:0] + cnt[4:0];
  assign spr    = {mem_q, 56'd0};
  assign rot    = {spr, spr} >> vx[5:0];
  assign mask   = rot[63:0];
  assign i_sum  = {1'b0, idx} + 13'(vx);
  assign sp_dec = (sp == '0) ? SP_LAST : sp - 1'b1;
  assign sp_inc = (sp == SP_LAST) ? '0 : sp + 1'b1;
  assign key_hit = in_keys[vx[3:0]];
  assign key_any = |in_keys;
  assign ax = (x == REG_VF) ? {7'd0, flag} : vx;
  assign by = (y == REG_VF) ? {7'd0, flag} : vy;

  always_comb begin
    kidx = 4'd0;
    for (int k = 15; k >= 0; k--) begin
      if (in_keys[k]) kidx = 4'(k);
    end
  end

  always_comb begin
    loop_cmd = 1'b0;
    inc_cmd  = 1'b0;
    sts.op   = op;
    sts.last = 1'b0;
    case (ctl.cmd)
      CMD_CLEAR:    begin loop_cmd = 1'b1; inc_cmd = 1'b1; sts.last = (cnt == 12'hFFF); end
      CMD_CLS:      begin loop_cmd = 1'b1; inc_cmd = 1'b1; sts.last = (cnt[4:0] == 5'd31); end
      CMD_DRAW_RD:  loop_cmd = 1'b1;
      CMD_DRAW_WR:  begin
        loop_cmd = 1'b1; inc_cmd = 1'b1; sts.last = (cnt[3:0] == n - 4'd1);
      end
      CMD_BCD:      begin loop_cmd = 1'b1; inc_cmd = 1'b1; sts.last = (cnt[1:0] == 2'd2); end
      CMD_STORE_RD: loop_cmd = 1'b1;
      CMD_STORE_WR: begin loop_cmd = 1'b1; inc_cmd = 1'b1; sts.last = (cnt[3:0] == x); end
      CMD_LOAD_RD:  loop_cmd = 1'b1;
      CMD_LOAD_WR:  begin loop_cmd = 1'b1; inc_cmd = 1'b1; sts.last = (cnt[3:0] == x); end
      default:      sts.last = 1'b0;
    endcase
  end

  // Memory port selection.
  always_comb begin
    mem_we     = 1'b0;
    mem_waddr  = i_off;
    mem_wdata  = reg_q;
    mem_raddr  = i_off;
    disp_we    = 1'b0;
    disp_waddr = drow;
    disp_wdata = disp_q ^ mask;
    disp_raddr = drow;
    reg_we     = 1'b0;
    reg_waddr  = x;
    reg_wdata  = vx;
    reg_raddr  = cnt[3:0];
    stk_we     = 1'b0;
    stk_raddr  = sp_dec;
    case (ctl.cmd)
      CMD_CLEAR: begin
        mem_we     = 1'b1;
        mem_waddr  = cnt;
        mem_wdata  = font_at(cnt);
        disp_we    = 1'b1;
        disp_waddr = cnt[4:0];
        disp_wdata = '0;
        reg_we     = 1'b1;
        reg_waddr  = cnt[3:0];
        reg_wdata  = 8'd0;
      end
      CMD_MEMWR: begin
        mem_we    = 1'b1;
        mem_waddr = in_addr;
        mem_wdata = in_data;
      end
      CMD_ROWRD: disp_raddr = in_row;
      CMD_F1:    mem_raddr = pc;
      CMD_F2:    mem_raddr = pc + 12'd1;
      CMD_F3:    reg_raddr = x;
      CMD_F4:    reg_raddr = y;
      CMD_F5:    reg_raddr = 4'd0;
      CMD_EXEC: begin
        case (opg)
          OPG_CALL: stk_we = 1'b1;
          OPG_LDI:  begin reg_we = 1'b1; reg_wdata = nn; end
          OPG_ADDI: begin reg_we = 1'b1; reg_wdata = vx + nn; end
          OPG_ALU: begin
            if (alu_sets_flag(n)) begin
              reg_we    = 1'b1;
              reg_waddr = REG_VF;
              reg_wdata = {7'd0, alu_flag(n, vx, vy)};
            end else if (n <= ALU_XOR) begin
              reg_we    = 1'b1;
              reg_wdata = alu_result(n, vx, vy);
            end
          end
          OPG_RND: begin reg_we = 1'b1; reg_wdata = in_rand & nn; end
          OPG_MISC: begin
            if (nn == FN_GET_DT) begin
              reg_we    = 1'b1;
              reg_wdata = dt;
            end else if (nn == FN_WAITK) begin
              reg_we    = key_any;
              reg_wdata = 8'(kidx);
            end else if (nn == FN_ADD_I) begin
              reg_we    = i_sum[12];
              reg_waddr = REG_VF;
              reg_wdata = 8'd1;
            end
          end
          default: reg_we = 1'b0;
        endcase
      end
      CMD_WRX: begin
        reg_we    = 1'b1;
        reg_wdata = alu_result(n, ax, by);
      end
      CMD_CLS: begin
        disp_we    = 1'b1;
        disp_waddr = cnt[4:0];
        disp_wdata = '0;
      end
      CMD_DRAW_WR: disp_we = 1'b1;
      CMD_DRAW_VF: begin
        reg_we    = 1'b1;
        reg_waddr = REG_VF;
        reg_wdata = {7'd0, coll};
      end
      CMD_BCD: begin
        mem_we    = 1'b1;
        mem_wdata = bcd_digit(vx, cnt[1:0]);
      end
      CMD_STORE_WR: mem_we = 1'b1;
      CMD_LOAD_WR: begin
        reg_we    = 1'b1;
        reg_waddr = cnt[3:0];
        reg_wdata = mem_q;
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      in_mode <= mode;
      in_addr <= address;
      in_data <= data_byte;
      in_keys <= keys;
      in_rand <= random_byte;
      in_row  <= row_index;
    end
    case (ctl.cmd)
      CMD_ROWCAP: row_r <= disp_q;
      CMD_F2:     op[15:8] <= mem_q;
      CMD_F3:     op[7:0] <= mem_q;
      CMD_F4:     vx <= reg_q;
      CMD_F5:     vy <= reg_q;
      CMD_F6:     v0 <= reg_q;
      CMD_EXEC:   flag <= alu_flag(n, vx, vy);
      default:    flag <= flag;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc      <= START_PC;
      idx     <= 12'd0;
      sp      <= '0;
      dt      <= 8'd0;
      st      <= 8'd0;
      cnt     <= 12'd0;
      coll    <= 1'b0;
      changed <= 1'b0;
      unk     <= 1'b0;
      waiting <= 1'b0;
    end else begin
      if (!loop_cmd) begin
        cnt <= 12'd0;
      end else if (inc_cmd) begin
        cnt <= cnt + 12'd1;
      end
      if (ctl.accept) begin
        changed <= 1'b0;
        unk     <= 1'b0;
        waiting <= 1'b0;
      end
      case (ctl.cmd)
        CMD_F3: pc <= pc + 12'd2;
        CMD_EXEC: begin
          case (opg)
            OPG_SYS: begin
              if (nnn == SYS_CLS) changed <= 1'b1;
              else if (nnn == SYS_RET) sp <= sp_dec;
              else unk <= 1'b1;
            end
            OPG_JP:   pc <= nnn;
            OPG_CALL: begin sp <= sp_inc; pc <= nnn; end
            OPG_SE:   if (vx == nn) pc <= pc + 12'd2;
            OPG_SNE:  if (vx != nn) pc <= pc + 12'd2;
            OPG_SER:  if (vx == vy) pc <= pc + 12'd2;
            OPG_SNER: if (vx != vy) pc <= pc + 12'd2;
            OPG_ALU:  if (!alu_known(n)) unk <= 1'b1;
            OPG_LDIDX: idx <= nnn;
            OPG_JPV0: pc <= nnn + 12'(v0);
            OPG_DRW:  begin changed <= 1'b1; coll <= 1'b0; end
            OPG_KEY: begin
              if (nn == KEY_DOWN) begin
                if (key_hit) pc <= pc + 12'd2;
              end else if (nn == KEY_UP) begin
                if (!key_hit) pc <= pc + 12'd2;
              end else begin
                unk <= 1'b1;
              end
            end
            OPG_MISC: begin
              case (nn)
                FN_GET_DT, FN_BCD, FN_STORE, FN_LOAD: unk <= 1'b0;
                FN_SET_DT: dt <= vx;
                FN_SET_ST: st <= vx;
                FN_ADD_I:  idx <= i_sum[11:0];
                FN_FONT:   idx <= FONT_BASE + 12'(vx[3:0]) * 12'd5;
                FN_WAITK: begin
                  if (!key_any) begin
                    waiting <= 1'b1;
                    pc      <= pc - 12'd2;
                  end
                end
                default: unk <= 1'b1;
              endcase
            end
            default: unk <= unk;
          endcase
        end
        CMD_RET:     pc <= stk_q;
        CMD_DRAW_WR: if (|(disp_q & mask)) coll <= 1'b1;
        CMD_TICK: begin
          if (dt != 8'd0) dt <= dt - 8'd1;
          if (st != 8'd0) st <= st - 8'd1;
        end
        default: pc <= pc;
      endcase
    end
  end

  cic_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_main_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .q(mem_q)
  );

  cic_ram #(.WIDTH(SCREEN_COLS), .DEPTH(SCREEN_ROWS)) u_display (
    .clk(clk), .we(disp_we), .waddr(disp_waddr), .wdata(disp_wdata),
    .raddr(disp_raddr), .q(disp_q)
  );

  cic_ram #(.WIDTH(8), .DEPTH(NUM_REGS)) u_regs (
    .clk(clk), .we(reg_we), .waddr(reg_waddr), .wdata(reg_wdata),
    .raddr(reg_raddr), .q(reg_q)
  );

  cic_ram #(.WIDTH(12), .DEPTH(STACK_DEPTH)) u_stack (
    .clk(clk), .we(stk_we), .waddr(sp), .wdata(pc),
    .raddr(stk_raddr), .q(stk_q)
  );

  assign program_counter = pc;
  assign instruction     = (in_mode == MODE_EXEC) ? op : 16'd0;
  assign display_changed = changed;
  assign sound_on        = (st != 8'd0);
  assign unknown_opcode  = unk;
  assign waiting_for_key = waiting;
  assign row_pixels      = (in_mode == MODE_ROW) ? row_r : 64'd0;

endmodule

// ===== rtl/core/chip8_instruction_core.sv =====
// CHIP-8 instruction core, driven one transaction at a time.
// Input channel: a transaction is taken on a rising edge with start high and
// busy low; mode selects a memory byte load, one instruction, or a display
// row read. The other input fields are sampled on that same edge.
// Output channel: done is high for exactly one cycle and the result ports
// are valid in that cycle. The receiver cannot stall, so every result must
// be taken when done is high; busy stays high until the cycle after done.
// Each transaction walks controller states that end in done: unused mode 3
// goes straight to done, a load byte writes memory, a row read reads and
// then captures the row, and an instruction passes fetch and operand reads
// F1 to F6, execute and the timer tick. A flag-setting ALU operation or a
// return adds a write-back state. Display clear and BCD write one entry per
// state; sprite rows and V0..VX store or load use a read and a write state.
// Only one transaction is in flight at a time.
// After reset the core runs a clearing pass that writes the hex font and
// zeros into main memory and zeros the display and registers; busy is high
// throughout, so no transaction is accepted until it ends.
module chip8_instruction_core #(
  parameter int STACK_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  output logic        done,
  input  logic [1:0]  mode,
  input  logic [11:0] address,
  input  logic [7:0]  data_byte,
  input  logic [15:0] keys,
  input  logic [7:0]  random_byte,
  input  logic [4:0]  row_index,
  output logic [11:0] program_counter,
  output logic [15:0] instruction,
  output logic        display_changed,
  output logic        sound_on,
  output logic        unknown_opcode,
  output logic        waiting_for_key,
  output logic [63:0] row_pixels
);
  import cic_pkg::*;

  // Controller and datapath talk only through these two bundles.
  ctl_t ctl;
  sts_t sts;

  // The controller sequences fetch, operand reads, execution, the
  // multi-cycle memory walks and the timer tick.
  cic_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .mode  (mode),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy),
    .done  (done)
  );

  // The datapath holds all machine state and the four memories.
  cic_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
    .clk             (clk),
    .rst             (rst),
    .ctl             (ctl),
    .sts             (sts),
    .mode            (mode),
    .address         (address),
    .data_byte       (data_byte),
    .keys            (keys),
    .random_byte     (random_byte),
    .row_index       (row_index),
    .program_counter (program_counter),
    .instruction     (instruction),
    .display_changed (display_changed),
    .sound_on        (sound_on),
    .unknown_opcode  (unknown_opcode),
    .waiting_for_key (waiting_for_key),
    .row_pixels      (row_pixels)
  );

endmodule

// ===== bench/chip8_instruction_core_tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the CHIP-8 instruction core.
// A scoreboard object keeps its own copy of the machine (memory, display,
// registers, stack and timers). Each accepted transaction is run through
// that copy to produce the expected result. Each done strobe is then
// compared, field by field, with the oldest expected result.
// Most random stimulus writes an instruction at the predicted program
// counter and then executes it. This keeps the core running real programs
// with random content, while raw fetches, row reads, stray memory writes
// and the unused mode add noise.
module chip8_instruction_core_tb;
  import cic_pkg::*;

  // Mode 3 is not decoded by the core; it must behave as an empty load.
  localparam logic [1:0] MODE_NONE = 2'd3;
  localparam int CYCLE_LIMIT = 600000;
  // Each random round sends about 2.4 transactions on average.
  localparam int RANDOM_ROUNDS = 480;

  typedef struct {
    logic [1:0]  mode;
    logic [11:0] address;
    logic [7:0]  data_byte;
    logic [15:0] keys;
    logic [7:0]  random_byte;
    logic [4:0]  row_index;
  } cmd_item_t;

  typedef struct {
    logic [11:0] program_counter;
    logic [15:0] instruction;
    logic        display_changed;
    logic        sound_on;
    logic        unknown_opcode;
    logic        waiting_for_key;
    logic [63:0] row_pixels;
  } step_result_t;

  // Scoreboard: a software copy of the machine plus a queue of the results
  // that the core still owes.
  class chip8_scoreboard;
    logic [7:0]   mem[MEM_DEPTH];
    logic [63:0]  rows[SCREEN_ROWS];
    logic [7:0]   v[NUM_REGS];
    logic [11:0]  idx;
    logic [11:0]  pc;
    logic [11:0]  stk[16];
    bit           stk_valid[16];
    logic [3:0]   sp;
    logic [7:0]   dt;
    logic [7:0]   st;
    step_result_t owed[$];
    int           errors;

    function new();
      for (int i = 0; i < MEM_DEPTH; i++) mem[i] = 8'h00;
      for (int i = 0; i < FONT_BYTES; i++) mem[int'(FONT_BASE) + i] = FONT[i];
      for (int i = 0; i < SCREEN_ROWS; i++) rows[i] = '0;
      for (int i = 0; i < NUM_REGS; i++) v[i] = 8'h00;
      for (int i = 0; i < 16; i++) stk_valid[i] = 1'b0;
      idx = '0;
      pc = START_PC;
      sp = '0;
      dt = '0;
      st = '0;
      errors = 0;
    endfunction

    function logic [15:0] next_opcode();
      return {mem[pc], mem[pc + 12'd1]};
    endfunction

    // True when executing now would return through a stack entry that no
    // call has written since reset.
    function bit return_unsafe();
      return next_opcode() == {4'h0, SYS_RET} && !stk_valid[sp - 4'd1];
    endfunction

    function void note(cmd_item_t it);
      step_result_t r;
      logic [15:0] op;
      logic [3:0] x, y, n;
      logic [7:0] nn, a, b;
      logic [11:0] nnn;
      logic [12:0] sum;
      logic [5:0] col;
      logic [4:0] rowi;
      logic [7:0] bits;
      r = '{default: '0};
      op = '0;
      if (it.mode == MODE_LOAD) begin
        mem[it.address] = it.data_byte;
      end else if (it.mode == MODE_ROW) begin
        r.row_pixels = rows[it.row_index];
      end else if (it.mode == MODE_EXEC) begin
        op = next_opcode();
        x = op[11:8];
        y = op[7:4];
        n = op[3:0];
        nn = op[7:0];
        nnn = op[11:0];
        pc = pc + 12'd2;
        case (op[15:12])
          OPG_SYS: begin
            if (nnn == SYS_CLS) begin
              for (int i = 0; i < SCREEN_ROWS; i++) rows[i] = '0;
              r.display_changed = 1'b1;
            end else if (nnn == SYS_RET) begin
              sp = sp - 4'd1;
              pc = stk_valid[sp] ? stk[sp] : 12'h000;
            end else begin
              r.unknown_opcode = 1'b1;
            end
          end
          OPG_JP: pc = nnn;
          OPG_CALL: begin
            stk[sp] = pc;
            stk_valid[sp] = 1'b1;
            sp = sp + 4'd1;
            pc = nnn;
          end
          OPG_SE:   if (v[x] == nn) pc = pc + 12'd2;
          OPG_SNE:  if (v[x] != nn) pc = pc + 12'd2;
          OPG_SER:  if (v[x] == v[y]) pc = pc + 12'd2;
          OPG_LDI:  v[x] = nn;
          OPG_ADDI: v[x] = v[x] + nn;
          OPG_ALU: begin
            // The flag lands first; the result then uses the updated file.
            a = v[x];
            b = v[y];
            case (n)
              ALU_MOV: v[x] = v[y];
              ALU_OR:  v[x] = v[x] | v[y];
              ALU_AND: v[x] = v[x] & v[y];
              ALU_XOR: v[x] = v[x] ^ v[y];
              ALU_ADD: begin
                v[REG_VF] = ({1'b0, a} + {1'b0, b} > 9'd255) ? 8'd1 : 8'd0;
                v[x] = v[x] + v[y];
              end
              ALU_SUB: begin
                v[REG_VF] = (a >= b) ? 8'd1 : 8'd0;
                v[x] = v[x] - v[y];
              end
              ALU_SHR: begin
                v[REG_VF] = {7'd0, a[0]};
                v[x] = v[x] >> 1;
              end
              ALU_SBN: begin
                v[REG_VF] = (b >= a) ? 8'd1 : 8'd0;
                v[x] = v[y] - v[x];
              end
              ALU_SHL: begin
                v[REG_VF] = {7'd0, a[7]};
                v[x] = v[x] << 1;
              end
              default: r.unknown_opcode = 1'b1;
            endcase
          end
          OPG_SNER:  if (v[x] != v[y]) pc = pc + 12'd2;
          OPG_LDIDX: idx = nnn;
          OPG_JPV0:  pc = nnn + {4'h0, v[0]};
          OPG_RND:   v[x] = it.random_byte & nn;
          OPG_DRW: begin
            a = v[x];
            b = v[y];
            v[REG_VF] = 8'd0;
            for (int rr = 0; rr < n; rr++) begin
              bits = mem[idx + 12'(rr)];
              rowi = b[4:0] + 5'(rr);
              for (int c = 0; c < 8; c++) begin
                if (bits[7 - c]) begin
                  col = a[5:0] + 6'(c);
                  if (rows[rowi][63 - col]) v[REG_VF] = 8'd1;
                  rows[rowi][63 - col] = ~rows[rowi][63 - col];
                end
              end
            end
            r.display_changed = 1'b1;
          end
          OPG_KEY: begin
            if (nn == KEY_DOWN) begin
              if (it.keys[v[x][3:0]]) pc = pc + 12'd2;
            end else if (nn == KEY_UP) begin
              if (!it.keys[v[x][3:0]]) pc = pc + 12'd2;
            end else begin
              r.unknown_opcode = 1'b1;
            end
          end
          default: begin
            case (nn)
              FN_GET_DT: v[x] = dt;
              FN_SET_DT: dt = v[x];
              FN_SET_ST: st = v[x];
              FN_ADD_I: begin
                sum = {1'b0, idx} + {5'd0, v[x]};
                if (sum[12]) v[REG_VF] = 8'd1;
                idx = sum[11:0];
              end
              FN_WAITK: begin
                r.waiting_for_key = 1'b1;
                for (int k = 0; k < 16; k++) begin
                  if (r.waiting_for_key && it.keys[k]) begin
                    v[x] = 8'(k);
                    r.waiting_for_key = 1'b0;
                  end
                end
                if (r.waiting_for_key) pc = pc - 12'd2;
              end
              FN_FONT: idx = FONT_BASE + 12'd5 * {8'd0, v[x][3:0]};
              FN_BCD: begin
                mem[idx] = v[x] / 8'd100;
                mem[idx + 12'd1] = (v[x] / 8'd10) % 8'd10;
                mem[idx + 12'd2] = v[x] % 8'd10;
              end
              FN_STORE: for (int i = 0; i <= x; i++) mem[idx + 12'(i)] = v[i];
              FN_LOAD:  for (int i = 0; i <= x; i++) v[i] = mem[idx + 12'(i)];
              default:  r.unknown_opcode = 1'b1;
            endcase
          end
        endcase
        if (dt != 0) dt = dt - 8'd1;
        if (st != 0) st = st - 8'd1;
      end
      r.program_counter = pc;
      r.instruction = op;
      r.sound_on = (st != 0);
      owed.push_back(r);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check(step_result_t got);
      step_result_t w;
      if (owed.size() == 0) begin
        report("unexpected transaction result", 64'(got.program_counter), 64'd0);
      end else begin
        w = owed.pop_front();
        if (got.program_counter !== w.program_counter)
          report("program_counter", 64'(got.program_counter), 64'(w.program_counter));
        if (got.instruction !== w.instruction)
          report("instruction", 64'(got.instruction), 64'(w.instruction));
        if (got.display_changed !== w.display_changed)
          report("display_changed", 64'(got.display_changed), 64'(w.display_changed));
        if (got.sound_on !== w.sound_on)
          report("sound_on", 64'(got.sound_on), 64'(w.sound_on));
        if (got.unknown_opcode !== w.unknown_opcode)
          report("unknown_opcode", 64'(got.unknown_opcode), 64'(w.unknown_opcode));
        if (got.waiting_for_key !== w.waiting_for_key)
          report("waiting_for_key", 64'(got.waiting_for_key), 64'(w.waiting_for_key));
        if (got.row_pixels !== w.row_pixels)
          report("row_pixels", got.row_pixels, w.row_pixels);
      end
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        done;
  logic [1:0]  mode;
  logic [11:0] address;
  logic [7:0]  data_byte;
  logic [15:0] keys;
  logic [7:0]  random_byte;
  logic [4:0]  row_index;
  logic [11:0] program_counter;
  logic [15:0] instruction;
  logic        display_changed;
  logic        sound_on;
  logic        unknown_opcode;
  logic        waiting_for_key;
  logic [63:0] row_pixels;

  chip8_scoreboard machine_sb;
  int  cycle_count;
  bit  idle_enabled;

  chip8_instruction_core u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
    .mode(mode), .address(address), .data_byte(data_byte), .keys(keys),
    .random_byte(random_byte), .row_index(row_index),
    .program_counter(program_counter), .instruction(instruction),
    .display_changed(display_changed), .sound_on(sound_on),
    .unknown_opcode(unknown_opcode), .waiting_for_key(waiting_for_key),
    .row_pixels(row_pixels)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The watchdog covers the clearing pass plus every transaction at its worst
  // latency and the longest idle gaps, several times over.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Results cannot be held off, so every done strobe is checked on the edge
  // that ends its cycle.
  always @(posedge clk) begin
    step_result_t got;
    if (!rst && done) begin
      got.program_counter = program_counter;
      got.instruction = instruction;
      got.display_changed = display_changed;
      got.sound_on = sound_on;
      got.unknown_opcode = unknown_opcode;
      got.waiting_for_key = waiting_for_key;
      got.row_pixels = row_pixels;
      machine_sb.check(got);
    end
  end

  // Present one transaction from the falling edge and hold it until a rising
  // edge sees busy low. Start stays high afterwards so back-to-back
  // transactions need no extra assignment.
  task send(logic [1:0] m, logic [11:0] a, logic [7:0] d, logic [15:0] k,
            logic [7:0] rb, logic [4:0] ri);
    cmd_item_t it;
    @(negedge clk);
    mode = m;
    address = a;
    data_byte = d;
    keys = k;
    random_byte = rb;
    row_index = ri;
    start = 1'b1;
    do @(posedge clk); while (busy);
    it = '{m, a, d, k, rb, ri};
    machine_sb.note(it);
  endtask

  // Sender gap: about 17 percent of the time, drop start.
  task maybe_idle();
    int len;
    if (idle_enabled && $urandom_range(99) < 17) begin
      len = $urandom_range(6, 1);
      @(negedge clk);
      start = 1'b0;
      repeat (len - 1) @(negedge clk);
    end
  endtask

  function logic [15:0] pick_keys();
    int sel;
    sel = $urandom_range(99);
    if (sel < 30) return 16'h0000;
    if (sel < 60) return 16'h0001 << $urandom_range(15);
    return 16'($urandom);
  endfunction

  // Fetch and execute one instruction. A return through a stack entry never
  // written is steered away from by patching the opcode first.
  task execute();
    if (machine_sb.return_unsafe())
      send(MODE_LOAD, machine_sb.pc, {OPG_LDI, 4'h0}, pick_keys(), 8'($urandom), 5'd0);
    send(MODE_EXEC, 12'($urandom), 8'($urandom), pick_keys(), 8'($urandom),
         5'($urandom));
  endtask

  // Place an opcode at the predicted program counter, then run it.
  task run_opcode(logic [15:0] op);
    logic [11:0] at;
    at = machine_sb.pc;
    send(MODE_LOAD, at, op[15:8], pick_keys(), 8'($urandom), 5'($urandom));
    maybe_idle();
    send(MODE_LOAD, at + 12'd1, op[7:0], pick_keys(), 8'($urandom), 5'($urandom));
    maybe_idle();
    execute();
  endtask

  // Mostly well-formed opcodes of every group; the rest are undefined
  // encodings inside the system, ALU, key and misc groups.
  function logic [15:0] random_opcode();
    logic [3:0] grp;
    logic [11:0] low;
    logic [7:0] misc_fn[9];
    logic [3:0] alu_fn[9];
    int sel;
    misc_fn = '{FN_GET_DT, FN_WAITK, FN_SET_DT, FN_SET_ST, FN_ADD_I,
                FN_FONT, FN_BCD, FN_STORE, FN_LOAD};
    alu_fn = '{ALU_MOV, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD, ALU_SUB,
               ALU_SHR, ALU_SBN, ALU_SHL};
    grp = 4'($urandom_range(15));
    low = 12'($urandom);
    sel = $urandom_range(99);
    case (grp)
      OPG_SYS: begin
        if (sel < 40) low = SYS_CLS;
        else if (sel < 80) low = SYS_RET;
      end
      OPG_ALU:  if (sel < 85) low[3:0] = alu_fn[$urandom_range(8)];
      OPG_KEY: begin
        if (sel < 45) low[7:0] = KEY_DOWN;
        else if (sel < 90) low[7:0] = KEY_UP;
      end
      OPG_MISC: if (sel < 85) low[7:0] = misc_fn[$urandom_range(8)];
      default: ;
    endcase
    return {grp, low};
  endfunction

  initial begin
    int sel;
    machine_sb = new();
    cycle_count = 0;
    idle_enabled = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    mode = MODE_LOAD;
    address = '0;
    data_byte = '0;
    keys = '0;
    random_byte = '0;
    row_index = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part: both ends of the display, the unused mode, the top
    // byte of memory, then the flag-ordering cases of the ALU and a font
    // sprite draw.
    send(MODE_ROW, 12'h000, 8'h00, 16'h0000, 8'h00, 5'd0);
    send(MODE_ROW, 12'hFFF, 8'hFF, 16'hFFFF, 8'hFF, 5'd31);
    send(MODE_NONE, 12'hABC, 8'h5A, 16'h8001, 8'hA5, 5'd17);
    send(MODE_LOAD, 12'hFFF, 8'hFF, 16'h0000, 8'h00, 5'd0);
    run_opcode({OPG_LDI, 4'h0, 8'hFF});
    run_opcode({OPG_LDI, 4'h1, 8'h01});
    run_opcode({OPG_ALU, 4'h0, 4'h1, ALU_ADD});
    run_opcode({OPG_ALU, REG_VF, 4'h1, ALU_ADD});
    run_opcode({OPG_ALU, 4'h0, REG_VF, ALU_SUB});
    run_opcode({OPG_LDIDX, FONT_BASE});
    run_opcode({OPG_DRW, 4'h0, 4'h1, 4'h5});

    // Random part; the middle stretch runs with no sender gaps at all.
    for (int n = 0; n < RANDOM_ROUNDS; n++) begin
      idle_enabled = !(n >= 200 && n < 300);
      maybe_idle();
      sel = $urandom_range(99);
      if (sel < 70) run_opcode(random_opcode());
      else if (sel < 80) execute();
      else if (sel < 88)
        send(MODE_ROW, 12'($urandom), 8'($urandom), pick_keys(), 8'($urandom),
             5'($urandom));
      else if (sel < 96)
        send(MODE_LOAD, 12'($urandom), 8'($urandom), pick_keys(), 8'($urandom),
             5'($urandom));
      else
        send(MODE_NONE, 12'($urandom), 8'($urandom), pick_keys(), 8'($urandom),
             5'($urandom));
    end

    @(negedge clk);
    start = 1'b0;
    while (machine_sb.owed.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (machine_sb.errors == 0 && machine_sb.owed.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/cic_pkg.sv
rtl/core/cic_ram.sv
rtl/core/cic_ctrl.sv
rtl/core/cic_datapath.sv
rtl/core/chip8_instruction_core.sv
bench/chip8_instruction_core_tb.sv
